### hdl/mie_pkg.sv
// Shared types, codes and the control program of the modular inverse block.
// Used by the sequencer and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mie_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    typedef logic [3:0] step_t;
    typedef logic [2:0] cond_t;
    typedef logic [2:0] op_t;

    // Program steps.
    localparam step_t STEP_IDLE   = 4'd0;
    localparam step_t STEP_TEST   = 4'd1;
    localparam step_t STEP_DSTART = 4'd2;
    localparam step_t STEP_DWAIT  = 4'd3;
    localparam step_t STEP_UPDATE = 4'd4;
    localparam step_t STEP_MTEST  = 4'd5;
    localparam step_t STEP_RSTART = 4'd6;
    localparam step_t STEP_RWAIT  = 4'd7;
    localparam step_t STEP_EMIT   = 4'd8;

    // Jump conditions.
    localparam cond_t COND_ALWAYS   = 3'd0;
    localparam cond_t COND_IN_VALID = 3'd1;
    localparam cond_t COND_B_ZERO   = 3'd2;
    localparam cond_t COND_M_ZERO   = 3'd3;
    localparam cond_t COND_DIV_DONE = 3'd4;
    localparam cond_t COND_OUT_FREE = 3'd5;

    // Datapath operations.
    localparam op_t OP_NONE    = 3'd0;
    localparam op_t OP_LOAD    = 3'd1;
    localparam op_t OP_DIV_EUC = 3'd2;
    localparam op_t OP_UPDATE  = 3'd3;
    localparam op_t OP_DIV_RED = 3'd4;
    localparam op_t OP_EMIT    = 3'd5;

    // One control word: when cond holds, op is carried out and the step
    // jumps to target; otherwise the step holds or moves on by one.
    typedef struct packed {
        cond_t cond;
        step_t target;
        logic  hold;
        op_t   op;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic b_zero;
        logic m_zero;
        logic div_done;
        logic out_free;
    } flags_t;

    typedef struct packed {
        logic  idle;
        step_t step;
        op_t   op;
    } seq_ctl_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        unique case (step)
            STEP_IDLE:   w = '{COND_IN_VALID, STEP_TEST,   1'b1, OP_LOAD};
            STEP_TEST:   w = '{COND_B_ZERO,   STEP_MTEST,  1'b0, OP_NONE};
            STEP_DSTART: w = '{COND_ALWAYS,   STEP_DWAIT,  1'b0, OP_DIV_EUC};
            STEP_DWAIT:  w = '{COND_DIV_DONE, STEP_UPDATE, 1'b1, OP_NONE};
            STEP_UPDATE: w = '{COND_ALWAYS,   STEP_TEST,   1'b0, OP_UPDATE};
            STEP_MTEST:  w = '{COND_M_ZERO,   STEP_EMIT,   1'b0, OP_NONE};
            STEP_RSTART: w = '{COND_ALWAYS,   STEP_RWAIT,  1'b0, OP_DIV_RED};
            STEP_RWAIT:  w = '{COND_DIV_DONE, STEP_EMIT,   1'b1, OP_NONE};
            STEP_EMIT:   w = '{COND_OUT_FREE, STEP_IDLE,   1'b1, OP_EMIT};
            default:     w = '{COND_ALWAYS,   STEP_IDLE,   1'b0, OP_NONE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### hdl/mie_div.sv
// Iterative restoring divider, one quotient bit per cycle, which also forms
// the product of the quotient with a side operand by shift and add.
// Depends on nothing beyond its parameter.
`timescale 1ns / 1ps
`default_nettype none

module mie_div #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DATA_WIDTH-1:0] dividend,
    input  wire logic [DATA_WIDTH-1:0] divisor,
    input  wire logic [DATA_WIDTH-1:0] mult,
    output logic                       done,
    output logic [DATA_WIDTH-1:0]      rem,
    output logic [DATA_WIDTH-1:0]      prod
);

    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] dvd_reg, dvd_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] dsr_reg, dsr_next;
    logic [DATA_WIDTH-1:0] mul_reg, mul_next;
    logic [DATA_WIDTH-1:0] prod_reg, prod_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;
    logic                  ge;

    assign trial = {rem_reg, dvd_reg[DATA_WIDTH-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        mul_next  = mul_reg;
        prod_next = prod_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            mul_next  = mult;
            prod_next = '0;
            cnt_next  = CW'(DATA_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next  = {dvd_reg[DATA_WIDTH-2:0], 1'b0};
            rem_next  = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
            // Quotient bits arrive most significant first, so the product
            // builds up as in a shift-and-add multiplier.
            prod_next = {prod_reg[DATA_WIDTH-2:0], 1'b0} + (ge ? mul_reg : '0);
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        mul_reg  <= mul_next;
        prod_reg <= prod_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;
    assign prod = prod_reg;

endmodule

`default_nettype wire

### hdl/mie_useq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on mie_pkg for the control word format and the program itself.
`timescale 1ns / 1ps
`default_nettype none

module mie_useq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mie_pkg::flags_t  flags,
    output mie_pkg::seq_ctl_t     ctl
);

    import mie_pkg::*;

    step_t  step_reg, step_next;
    ucode_t word;
    logic   cond_ok;

    assign word = ucode_rom(step_reg);

    always_comb
    begin
        unique case (word.cond)
            COND_ALWAYS:   cond_ok = 1'b1;
            COND_IN_VALID: cond_ok = flags.in_valid;
            COND_B_ZERO:   cond_ok = flags.b_zero;
            COND_M_ZERO:   cond_ok = flags.m_zero;
            COND_DIV_DONE: cond_ok = flags.div_done;
            COND_OUT_FREE: cond_ok = flags.out_free;
            default:       cond_ok = 1'b1;
        endcase
    end

    always_comb
    begin
        if (cond_ok)
            step_next = word.target;
        else if (word.hold)
            step_next = step_reg;
        else
            step_next = step_reg + step_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_IDLE;
        else
            step_reg <= step_next;
    end

    assign ctl.idle = (step_reg == STEP_IDLE);
    assign ctl.step = step_reg;
    assign ctl.op   = cond_ok ? word.op : OP_NONE;

endmodule

`default_nettype wire

### hdl/modular_inverse_ext_euclid.sv
// The bit-serial divider serves every Euclid round and, for a nonzero modulus,
// the final reduction, so the time an item takes grows with its R rounds.
// At 32 bits R is at most 46.
// The next item is accepted only once the result of the last one has gone
// into the output register. Reset clears control state only.
// Top level: datapath registers, output register, divider and sequencer.
// Depends on mie_pkg, mie_div and mie_useq.
`timescale 1ns / 1ps
`default_nettype none

module modular_inverse_ext_euclid #(
    parameter int DATA_WIDTH = mie_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [DATA_WIDTH-1:0] value,
    input  wire logic [DATA_WIDTH-1:0] modulus,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [DATA_WIDTH-1:0]      inverse,
    output logic [DATA_WIDTH-1:0]      divisor
);

    import mie_pkg::*;

    logic [DATA_WIDTH-1:0] a_reg, b_reg, m_reg, sp_reg, sc_reg;
    logic                  odd_reg;
    logic [DATA_WIDTH-1:0] inverse_reg, divisor_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] inv_calc;

    flags_t                flags;
    seq_ctl_t              ctl;

    logic                  div_start;
    logic [DATA_WIDTH-1:0] div_dividend, div_divisor, div_mult;
    logic                  div_done;
    logic [DATA_WIDTH-1:0] div_rem, div_prod;

    assign flags.in_valid = in_valid;
    assign flags.b_zero   = (b_reg == '0);
    assign flags.m_zero   = (m_reg == '0);
    assign flags.div_done = div_done;
    assign flags.out_free = !out_valid_reg || !out_stall;

    mie_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctl   (ctl)
    );

    assign div_start    = (ctl.op == OP_DIV_EUC) || (ctl.op == OP_DIV_RED);
    assign div_dividend = (ctl.op == OP_DIV_RED) ? sp_reg : a_reg;
    assign div_divisor  = (ctl.op == OP_DIV_RED) ? m_reg  : b_reg;
    assign div_mult     = (ctl.op == OP_DIV_RED) ? '0     : sc_reg;

    mie_div #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .mult     (div_mult),
        .done     (div_done),
        .rem      (div_rem),
        .prod     (div_prod)
    );

    // Only magnitudes of the coefficients are kept; an odd index means the
    // true coefficient is negative, so the reduced value is folded over.
    always_comb
    begin
        if (m_reg == '0)
            inv_calc = '0;
        else if (odd_reg && (div_rem != '0))
            inv_calc = m_reg - div_rem;
        else
            inv_calc = div_rem;
    end

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            OP_LOAD:
            begin
                a_reg   <= value;
                b_reg   <= modulus;
                m_reg   <= modulus;
                sp_reg  <= DATA_WIDTH'(1);
                sc_reg  <= '0;
                odd_reg <= 1'b0;
            end
            OP_UPDATE:
            begin
                sp_reg  <= sc_reg;
                sc_reg  <= sp_reg + div_prod;
                a_reg   <= b_reg;
                b_reg   <= div_rem;
                odd_reg <= !odd_reg;
            end
            OP_EMIT:
            begin
                inverse_reg <= inv_calc;
                divisor_reg <= a_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (ctl.op == OP_EMIT)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign in_stall  = !ctl.idle;
    assign out_valid = out_valid_reg;
    assign inverse   = inverse_reg;
    assign divisor   = divisor_reg;

`ifndef ASSERT_OFF
    a_load_init: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_LOAD) |=> (sp_reg == DATA_WIDTH'(1)) && (sc_reg == '0) && !odd_reg)
        else $error("coefficients not initialised after an item was taken");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (ctl.step == STEP_DWAIT) || (ctl.step == STEP_RWAIT))
        else $error("divider finished outside a wait step");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_EMIT) |=> out_valid_reg)
        else $error("result written without raising out_valid");

    a_inv_range: assert property (@(posedge clk) disable iff (!rst_n)
        $past(ctl.op == OP_EMIT) |-> (m_reg == '0) || (inverse_reg < m_reg))
        else $error("inverse not reduced below the modulus");
`endif

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for modular_inverse_ext_euclid: drives value/modulus pairs,
// predicts inverse and gcd with an extended Euclid model and checks every result item.
// Depends on mie_pkg and the RTL of the block; needs no other file.
`timescale 1ns / 1ps

module tb;

    localparam int W = mie_pkg::DATA_WIDTH_DEF;

    // Worst case: 46 rounds, plus stalls, taken several times.
    localparam longint TIMEOUT_NS = 20_000_000;
    localparam int     SETTLE_CYCLES = 2000;
    localparam int     HOLD_CYCLES = 5000;
    localparam int     RANDOM_CHUNK = 190;

    typedef logic [W-1:0] word_t;

    typedef struct packed {
        word_t value;
        word_t modulus;
    } operand_t;

    typedef struct packed {
        word_t inverse;
        word_t divisor;
    } inv_gcd_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    word_t value = '0;
    word_t modulus = '0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    word_t inverse;
    word_t divisor;

    operand_t operand_backlog[$];
    inv_gcd_t inv_gcd_due[$];

    int   n_queued = 0;
    int   n_accepted = 0;
    int   n_checked = 0;
    int   n_failures = 0;
    logic in_taken = 1'b0;
    logic rx_hold = 1'b0;
    logic calm;

    // A stretch of the run with no idling on either side.
    assign calm = (n_accepted >= 250) && (n_accepted < 330);

    modular_inverse_ext_euclid i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .modulus   (modulus),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .inverse   (inverse),
        .divisor   (divisor)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Extended Euclid on magnitudes; the sign of the coefficient follows the
    // parity of the number of rounds.
    function automatic inv_gcd_t predict_inverse(input word_t v, input word_t m);
        logic [63:0] a, b, sp, sc, sn, q, r, red, inv;
        bit odd;
        inv_gcd_t res;
        a = 64'(v);
        b = 64'(m);
        sp = 64'd1;
        sc = 64'd0;
        odd = 1'b0;
        while (b != 0)
        begin
            q = a / b;
            r = a - q * b;
            sn = sp + q * sc;
            sp = sc;
            sc = sn;
            a = b;
            b = r;
            odd = !odd;
        end
        if (m == 0)
        begin
            inv = 64'd0;
        end
        else
        begin
            red = sp % 64'(m);
            inv = (odd && red != 0) ? 64'(m) - red : red;
        end
        res.inverse = inv[W-1:0];
        res.divisor = a[W-1:0];
        return res;
    endfunction

    task automatic queue_operands(input word_t v, input word_t m);
        operand_t op;
        op.value = v;
        op.modulus = m;
        operand_backlog.push_back(op);
        n_queued++;
    endtask

    task automatic wait_all_results();
        while (n_accepted != n_queued || inv_gcd_due.size() != 0)
            @(negedge clk);
    endtask

    // Sender: a new item only once the previous one has been taken.
    always @(negedge clk)
    begin
        operand_t nxt;
        bit offer;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!(in_valid && !in_taken))
        begin
            offer = (operand_backlog.size() > 0) && (calm || $urandom_range(99) >= 10);
            if (offer)
            begin
                nxt = operand_backlog.pop_front();
                in_valid <= 1'b1;
                value <= nxt.value;
                modulus <= nxt.modulus;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random, plus one long hold-off.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= rx_hold || (!calm && $urandom_range(99) < 10);
    end

    // Input acceptance: record the item and its expected result.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            inv_gcd_due.push_back(predict_inverse(value, modulus));
            n_accepted++;
            in_taken <= 1'b1;
        end
        else
        begin
            in_taken <= 1'b0;
        end
    end

    // Output checking against the oldest expectation.
    always @(posedge clk)
    begin
        inv_gcd_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (inv_gcd_due.size() == 0)
            begin
                n_failures++;
                if (n_failures <= 10)
                    $display("ERROR: unexpected result inverse=%h divisor=%h", inverse, divisor);
            end
            else
            begin
                want = inv_gcd_due.pop_front();
                n_checked++;
                if (inverse !== want.inverse || divisor !== want.divisor)
                begin
                    n_failures++;
                    if (n_failures <= 10)
                        $display("ERROR: result %0d expected inverse=%h divisor=%h, got %h %h",
                                 n_checked, want.inverse, want.divisor, inverse, divisor);
                end
            end
        end
    end

    // Long receiver hold-off so that the block fills up and stalls its input.
    initial
    begin
        while (n_accepted < 70)
            @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        word_t v, m, g;
        int kind;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed items: extremes, longest Euclid chain and degenerate operands.
        queue_operands(32'd1, 32'd2);
        queue_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_operands(32'd1, 32'hFFFF_FFFF);
        queue_operands(32'hFFFF_FFFF, 32'd2);
        queue_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        queue_operands(32'd1836311903, 32'd2971215073);
        queue_operands(32'd2971215073, 32'd1836311903);
        queue_operands(32'd3, 32'd7);
        queue_operands(32'd10, 32'd17);
        queue_operands(32'd12, 32'd13);
        queue_operands(32'd6, 32'd9);
        queue_operands(32'h8000_0000, 32'hC000_0000);
        queue_operands(32'd100, 32'd7);
        queue_operands(32'hFFFF_FFFF, 32'd10);
        queue_operands(32'h5555_5555, 32'hAAAA_AAAA);
        queue_operands(32'hAAAA_AAAA, 32'h5555_5555);
        queue_operands(32'd2, 32'hFFFF_FFFB);
        queue_operands(32'd0, 32'd12345);
        queue_operands(32'd77, 32'd0);
        queue_operands(32'd5, 32'd1);
        queue_operands(32'd0, 32'd0);
        queue_operands(32'hFFFF_FFFF, 32'd0);
        wait_all_results();

        // Random items in two batches; the sender pauses for a full drain between them.
        repeat (2)
        begin
            repeat (RANDOM_CHUNK)
            begin
                kind = $urandom_range(99);
                if (kind < 60)
                begin
                    v = $urandom;
                    m = $urandom;
                end
                else if (kind < 75)
                begin
                    v = $urandom_range(1, 1000);
                    m = $urandom_range(2, 1000);
                end
                else if (kind < 88)
                begin
                    g = $urandom_range(2, 1000);
                    v = g * $urandom_range(1, 4000000);
                    m = g * $urandom_range(1, 4000000);
                end
                else
                begin
                    v = $urandom;
                    m = $urandom_range(2, 65535);
                end
                if (v == 0)
                    v = 1;
                if (m < 2)
                    m = 2;
                queue_operands(v, m);
            end
            wait_all_results();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (inv_gcd_due.size() != 0)
        begin
            n_failures += inv_gcd_due.size();
            $display("ERROR: %0d expected results never arrived", inv_gcd_due.size());
        end
        $display("Checked %0d results for %0d operand pairs, including degenerate operands,",
                 n_checked, n_accepted);
        $display("the longest Euclid chain, shared factors and a long output hold-off.");
        if (n_failures == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
